FILE: rtl/core/date_string_validator_top_assert.svh
// ----------------------------------------------------------------------------
// Date string validator - assertion macros
// Shared property forms for the validator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DATE_STRING_VALIDATOR_TOP_ASSERT_SVH
`define DATE_STRING_VALIDATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define DSV_CHECK_NOW(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("date string validator: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define DSV_CHECK_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("date string validator: next-cycle check failed");

`endif

FILE: rtl/core/dsv_pkg.sv
// ----------------------------------------------------------------------------
// Date string validator package
// Character codes, error codes, the finished-date record and month lengths.
// ----------------------------------------------------------------------------
package dsv_pkg;

   localparam int CHAR_W  = 8;
   localparam int POS_W   = 4;
   localparam int DAY_W   = 7;
   localparam int MONTH_W = 7;
   localparam int YEAR_W  = 14;
   localparam int PAIR_W  = 7;
   localparam int MLEN_W  = 5;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'd46;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

   // character positions in DD.MM.YYYY plus the trailing space
   localparam logic [POS_W-1:0] POS_DAY0   = 4'd0;
   localparam logic [POS_W-1:0] POS_DAY1   = 4'd1;
   localparam logic [POS_W-1:0] POS_DOT0   = 4'd2;
   localparam logic [POS_W-1:0] POS_MON0   = 4'd3;
   localparam logic [POS_W-1:0] POS_MON1   = 4'd4;
   localparam logic [POS_W-1:0] POS_DOT1   = 4'd5;
   localparam logic [POS_W-1:0] POS_YEAR0  = 4'd6;
   localparam logic [POS_W-1:0] POS_YEAR1  = 4'd7;
   localparam logic [POS_W-1:0] POS_YEAR2  = 4'd8;
   localparam logic [POS_W-1:0] POS_YEAR3  = 4'd9;
   localparam logic [POS_W-1:0] POS_SPACE  = 4'd10;
   localparam logic [POS_W-1:0] POS_SAT    = 4'd11;

   localparam logic [MONTH_W-1:0] MONTH_MAX = 7'd12;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 7'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 7'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 7'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 7'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 7'd11;

   localparam logic [MLEN_W-1:0] DAYS_FEB_LEAP = 5'd29;
   localparam logic [MLEN_W-1:0] DAYS_FEB      = 5'd28;
   localparam logic [MLEN_W-1:0] DAYS_SHORT    = 5'd30;
   localparam logic [MLEN_W-1:0] DAYS_LONG     = 5'd31;

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_FORMAT = 3'd1,
      ERR_YEAR   = 3'd2,
      ERR_MONTH  = 3'd3,
      ERR_DAY    = 3'd4
   } err_code_type;

   // finished date handed from the parser to the checker
   typedef struct packed {
      logic               fmt_err;   // bad character or string too short
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic [PAIR_W-1:0]  yr_hi;     // century digits, positions 6 and 7
      logic [PAIR_W-1:0]  yr_lo;     // year-in-century digits, positions 8 and 9
   } date_rec_type;

   function automatic logic [MLEN_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [MLEN_W-1:0] len;
      len = DAYS_LONG;
      if (month == MONTH_FEB) begin
         len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
      end else if (month == MONTH_APR || month == MONTH_JUN ||
                   month == MONTH_SEP || month == MONTH_NOV) begin
         len = DAYS_SHORT;
      end
      return len;
   endfunction

endpackage

FILE: rtl/core/date_string_validator_top.sv
// ----------------------------------------------------------------------------
// Date string validator
// Checks DD.MM.YYYY date text streamed one character per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one ASCII character per transfer in req_tdata; req_tlast
//   marks the final character of a date string. Only the final character
//   produces a transfer on rsp_*: validity, error code and the decoded day,
//   month and year.
//   Throughput is one character per cycle while req_tready is high. After the
//   final character is taken, the result passes through the parser's record
//   register and then the checker's output register.
//   Reset clears the position counter, the accumulators and both valid
//   flags, so the next character is taken as position 0 of a new string.
//   When rsp_tready is low the result is held; the parser keeps taking
//   characters and can park one more finished date, and only then drops
//   req_tready until the output register drains.
// ----------------------------------------------------------------------------
`include "date_string_validator_top_assert.svh"

module date_string_validator_top
   import dsv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [0] valid_res, [3:1] error_code, [10:4] day_out,
                                    // [17:11] month_out, [31:18] year_out
);

   logic               rec_valid;
   logic               rec_pop;
   date_rec_type       rec;
   logic               valid_res;
   logic [2:0]         error_code;
   logic [DAY_W-1:0]   day_out;
   logic [MONTH_W-1:0] month_out;
   logic [YEAR_W-1:0]  year_out;

   dsv_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .char_code (req_tdata),
      .last      (req_tlast),
      .rec_valid (rec_valid),
      .rec_pop   (rec_pop),
      .rec       (rec)
   );

   dsv_check u_check (
      .clock      (clock),
      .reset      (reset),
      .rec_valid  (rec_valid),
      .rec_pop    (rec_pop),
      .rec        (rec),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .valid_res  (valid_res),
      .error_code (error_code),
      .day_out    (day_out),
      .month_out  (month_out),
      .year_out   (year_out)
   );

   // pack the result fields from the lowest bit up
   assign rsp_tdata = {year_out, month_out, day_out, error_code, valid_res};

   // a final character always lands in the record register
   `DSV_CHECK_NEXT(a_last_makes_record, req_tvalid && req_tready && req_tlast, rec_valid)
   // a record moved on is shown to the receiver in the next cycle
   `DSV_CHECK_NEXT(a_pop_shows_result, rec_pop, rsp_tvalid)
   // valid flag agrees with the error code
   `DSV_CHECK_NOW(a_flag_matches_code, rsp_tvalid, valid_res == (error_code == ERR_NONE))
   // an accepted date has a real month and a nonzero day
   `DSV_CHECK_NOW(a_good_date_in_range, rsp_tvalid && valid_res,
      month_out != '0 && month_out <= MONTH_MAX && day_out != '0)

endmodule

FILE: rtl/core/dsv_parse.sv
// ----------------------------------------------------------------------------
// Date string parser
// Walks the characters of one date, builds day, month and year, and hands a
// finished record to the checker on the last character.
// ----------------------------------------------------------------------------
module dsv_parse
   import dsv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [CHAR_W-1:0]   char_code,
   input  logic                last,
   output logic                rec_valid,
   input  logic                rec_pop,
   output date_rec_type        rec
);

   logic [POS_W-1:0]   pos_ff,    pos_in;
   logic [DAY_W-1:0]   day_ff,    day_in;
   logic [MONTH_W-1:0] month_ff,  month_in;
   logic [YEAR_W-1:0]  year_ff,   year_in;
   logic [PAIR_W-1:0]  hi_ff,     hi_in;
   logic [PAIR_W-1:0]  lo_ff,     lo_in;
   logic               bad_ff,    bad_in;
   logic               rec_vld_ff;
   date_rec_type       rec_ff,    rec_in;
   logic               take;
   logic               is_digit;
   logic [3:0]         dval;

   // a slot is free when the record register is empty or drains this cycle
   assign in_ready  = !rec_vld_ff || rec_pop;
   assign take      = in_valid && in_ready;
   assign rec_valid = rec_vld_ff;
   assign rec       = rec_ff;

   // '0'..'9' are 0x30..0x39, so the low nibble is the digit value
   assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign dval     = is_digit ? char_code[3:0] : 4'd0;

   // advance the field accumulators for the character at the current position
   always_comb begin
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      bad_in   = bad_ff;
      case (pos_ff)
         POS_DAY0, POS_DAY1: begin
            if (is_digit) begin
               day_in = DAY_W'({day_ff, 3'b000} + {2'b00, day_ff, 1'b0} + {6'd0, dval});
            end else begin
               bad_in = 1'b1;
            end
         end
         POS_MON0, POS_MON1: begin
            if (is_digit) begin
               month_in = MONTH_W'({month_ff, 3'b000} + {2'b00, month_ff, 1'b0} +
                                   {6'd0, dval});
            end else begin
               bad_in = 1'b1;
            end
         end
         POS_YEAR0, POS_YEAR1, POS_YEAR2, POS_YEAR3: begin
            if (is_digit) begin
               year_in = YEAR_W'({year_ff, 3'b000} + {2'b00, year_ff, 1'b0} +
                                 {13'd0, dval});
               if (pos_ff == POS_YEAR0 || pos_ff == POS_YEAR1) begin
                  hi_in = PAIR_W'({hi_ff, 3'b000} + {2'b00, hi_ff, 1'b0} + {6'd0, dval});
               end else begin
                  lo_in = PAIR_W'({lo_ff, 3'b000} + {2'b00, lo_ff, 1'b0} + {6'd0, dval});
               end
            end else begin
               bad_in = 1'b1;
            end
         end
         POS_DOT0, POS_DOT1: begin
            if (char_code != CHAR_DOT) begin
               bad_in = 1'b1;
            end
         end
         POS_SPACE: begin
            if (char_code != CHAR_SPACE) begin
               bad_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
      pos_in = (pos_ff < POS_SAT) ? pos_ff + 4'd1 : pos_ff;
   end

   // record as it stands after the last character
   always_comb begin
      rec_in.fmt_err = bad_in || (pos_ff < POS_YEAR3);
      rec_in.day     = day_in;
      rec_in.month   = month_in;
      rec_in.year    = year_in;
      rec_in.yr_hi   = hi_in;
      rec_in.yr_lo   = lo_in;
   end

   // hold the parse state; clear it after the last character of a string
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         day_ff     <= '0;
         month_ff   <= '0;
         year_ff    <= '0;
         hi_ff      <= '0;
         lo_ff      <= '0;
         bad_ff     <= 1'b0;
         rec_vld_ff <= 1'b0;
      end else begin
         if (take) begin
            if (last) begin
               pos_ff   <= '0;
               day_ff   <= '0;
               month_ff <= '0;
               year_ff  <= '0;
               hi_ff    <= '0;
               lo_ff    <= '0;
               bad_ff   <= 1'b0;
            end else begin
               pos_ff   <= pos_in;
               day_ff   <= day_in;
               month_ff <= month_in;
               year_ff  <= year_in;
               hi_ff    <= hi_in;
               lo_ff    <= lo_in;
               bad_ff   <= bad_in;
            end
         end
         if (take && last) begin
            rec_vld_ff <= 1'b1;
         end else if (rec_pop) begin
            rec_vld_ff <= 1'b0;
         end
      end
   end

   // load the finished record
   always_ff @(posedge clock) begin
      if (take && last) begin
         rec_ff <= rec_in;
      end
   end

endmodule

FILE: rtl/core/dsv_check.sv
// ----------------------------------------------------------------------------
// Date checker
// Ranks the errors of a finished date and holds the result for the receiver.
// ----------------------------------------------------------------------------
module dsv_check
   import dsv_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               rec_valid,
   output logic               rec_pop,
   input  date_rec_type       rec,
   output logic               out_valid,
   input  logic               out_ready,
   output logic               valid_res,
   output logic [2:0]         error_code,
   output logic [DAY_W-1:0]   day_out,
   output logic [MONTH_W-1:0] month_out,
   output logic [YEAR_W-1:0]  year_out
);

   logic               out_vld_ff;
   err_code_type       err_ff,   err_in;
   logic [DAY_W-1:0]   day_ff;
   logic [MONTH_W-1:0] month_ff;
   logic [YEAR_W-1:0]  year_ff;
   logic               leap;
   logic [MLEN_W-1:0]  mlen;

   assign rec_pop = rec_valid && (!out_vld_ff || out_ready);

   // Gregorian leap year from the two digit pairs: the low pair divisible
   // by 4, and for a century year the century pair divisible by 4
   assign leap = (rec.yr_lo[1:0] == 2'b00) &&
                 ((rec.yr_lo != '0) || (rec.yr_hi[1:0] == 2'b00));
   assign mlen = month_len(rec.month, leap);

   // rank the errors: format, year, month, day
   always_comb begin
      if (rec.fmt_err) begin
         err_in = ERR_FORMAT;
      end else if (rec.year == '0) begin
         err_in = ERR_YEAR;
      end else if (rec.month == '0 || rec.month > MONTH_MAX) begin
         err_in = ERR_MONTH;
      end else if (rec.day == '0 || rec.day > {2'b00, mlen}) begin
         err_in = ERR_DAY;
      end else begin
         err_in = ERR_NONE;
      end
   end

   // hold the result until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (rec_pop) begin
         out_vld_ff <= 1'b1;
      end else if (out_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_pop) begin
         err_ff   <= err_in;
         day_ff   <= rec.day;
         month_ff <= rec.month;
         year_ff  <= rec.year;
      end
   end

   assign out_valid  = out_vld_ff;
   assign valid_res  = (err_ff == ERR_NONE);
   assign error_code = 3'(err_ff);
   assign day_out    = day_ff;
   assign month_out  = month_ff;
   assign year_out   = year_ff;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Date string validator testbench
// Streams DD.MM.YYYY text one character per transfer into the validator and
// predicts each result in step with the stimulus. Directed strings cover the
// calendar edges, every error code and the malformed shapes. Random strings
// follow: mostly well-formed dates with random content, plus corrupted,
// truncated and noise strings. Random gaps on both channels are included.
// ----------------------------------------------------------------------------
module tb_top;
   import dsv_pkg::*;

   typedef struct {
      logic               ok;
      err_code_type       err;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_result_type;

   localparam int IDLE_LIMIT = 4000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // [7:0] char_code
   logic        req_tlast  = 1'b0;   // last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [0] valid_res, [3:1] error_code, [10:4] day_out,
                                     // [17:11] month_out, [31:18] year_out

   // parser state mirrored from the accepted characters
   logic [POS_W-1:0]   char_pos;
   logic [DAY_W-1:0]   day_acc;
   logic [MONTH_W-1:0] month_acc;
   logic [YEAR_W-1:0]  year_acc;
   logic               fmt_bad;

   date_result_type expected_dates[$];
   logic [7:0]      text_q[$];
   int errors        = 0;
   int chars_sent    = 0;
   int strings_sent  = 0;
   int dates_checked = 0;
   int idle_cycles   = 0;
   int stall_left    = 0;
   bit tx_gaps_on    = 1'b0;
   bit rx_stalls_on  = 1'b0;

   date_string_validator_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic bit is_leap_year(int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int days_in_month(int m, int y);
      case (m)
         MONTH_FEB: return is_leap_year(y) ? DAYS_FEB_LEAP : DAYS_FEB;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return DAYS_SHORT;
         default: return DAYS_LONG;
      endcase
   endfunction

   function automatic void clear_date_state();
      char_pos  = '0;
      day_acc   = '0;
      month_acc = '0;
      year_acc  = '0;
      fmt_bad   = 1'b0;
   endfunction

   // advance the mirrored parser by one character, queue a date on the last one
   function automatic void parse_char(logic [7:0] c, logic l);
      logic            digit;
      int              d;
      logic [POS_W-1:0] p;
      date_result_type r;
      p     = char_pos;
      digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      d     = digit ? int'(c) - int'(CHAR_ZERO) : 0;
      case (p)
         POS_DAY0, POS_DAY1: begin
            if (digit) day_acc = DAY_W'(day_acc * 10 + d);
            else fmt_bad = 1'b1;
         end
         POS_MON0, POS_MON1: begin
            if (digit) month_acc = MONTH_W'(month_acc * 10 + d);
            else fmt_bad = 1'b1;
         end
         POS_YEAR0, POS_YEAR1, POS_YEAR2, POS_YEAR3: begin
            if (digit) year_acc = YEAR_W'(year_acc * 10 + d);
            else fmt_bad = 1'b1;
         end
         POS_DOT0, POS_DOT1: begin
            if (c != CHAR_DOT) fmt_bad = 1'b1;
         end
         POS_SPACE: begin
            if (c != CHAR_SPACE) fmt_bad = 1'b1;
         end
         default: ;
      endcase
      if (p < POS_SAT) char_pos = p + 1'b1;
      if (l) begin
         if (fmt_bad || p < POS_YEAR3) r.err = ERR_FORMAT;
         else if (year_acc == 0) r.err = ERR_YEAR;
         else if (month_acc == 0 || month_acc > MONTH_MAX) r.err = ERR_MONTH;
         else if (day_acc == 0 || day_acc > days_in_month(month_acc, year_acc))
            r.err = ERR_DAY;
         else r.err = ERR_NONE;
         r.ok    = (r.err == ERR_NONE);
         r.day   = day_acc;
         r.month = month_acc;
         r.year  = year_acc;
         expected_dates.push_back(r);
         clear_date_state();
      end
   endfunction

   function automatic void put_char(logic [7:0] c);
      text_q.push_back(c);
   endfunction

   function automatic void put_num(int val, int ndig);
      int div;
      div = 1;
      repeat (ndig - 1) div *= 10;
      repeat (ndig) begin
         put_char(8'(int'(CHAR_ZERO) + (val / div) % 10));
         div /= 10;
      end
   endfunction

   // one character transfer, preceded by an optional gap
   task automatic send_char(logic [7:0] c, logic l);
      int gap;
      gap = tx_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      parse_char(c, l);
      chars_sent++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) begin
         send_char(text_q[i], i == text_q.size() - 1);
      end
      strings_sent++;
   endtask

   task automatic send_str(string s);
      text_q.delete();
      for (int i = 0; i < s.len(); i++) put_char(s[i]);
      send_text();
   endtask

   // hold the sender until every queued date has come back
   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_dates.size() != 0);
   endtask

   // random DD.MM.YYYY, biased toward month ends and leap-year corners
   function automatic void build_date();
      int day;
      int month;
      int year;
      month = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
      case ($urandom_range(0, 5))
         0: year = $urandom_range(0, 9999);
         1: year = 4 * $urandom_range(0, 2499);
         2: year = 100 * $urandom_range(0, 99);
         3: year = 400 * $urandom_range(0, 24);
         4: year = $urandom_range(0, 40);
         default: year = $urandom_range(1582, 2100);
      endcase
      day = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 31);
      if (month >= 1 && month <= 12 && $urandom_range(0, 3) == 0)
         day = days_in_month(month, year) + $urandom_range(0, 1);
      put_num(day, 2);
      put_char(CHAR_DOT);
      put_num(month, 2);
      put_char(CHAR_DOT);
      put_num(year, 4);
      if ($urandom_range(0, 3) == 0) begin
         put_char(CHAR_SPACE);
         repeat ($urandom_range(0, 4)) put_char(8'($urandom_range(0, 255)));
      end
   endfunction

   task automatic test_valid_dates();
      send_str("01.01.0001");
      send_str("31.12.9999");
      send_str("29.02.2000");
      send_str("29.02.2024 ");
      send_str("30.11.1999 ok");
   endtask

   task automatic test_error_codes();
      send_str("29.02.1900");
      send_str("31.04.2021");
      send_str("00.07.2020");
      send_str("15.00.2020");
      send_str("15.13.2020");
      send_str("99.99.0000");
   endtask

   task automatic test_format_errors();
      send_str("1.01.2020");
      send_str("01.01.202");
      send_str("01/01.2020");
      send_str("01.01.20x0");
      send_str("01.01.2020x");
      // lowest and highest codes as one-character strings
      text_q.delete();
      put_char(8'h00);
      send_text();
      text_q.delete();
      put_char(8'hFF);
      send_text();
   endtask

   // position counter saturates, so any tail after the space is ignored
   task automatic test_long_strings();
      text_q.delete();
      put_num(28, 2);
      put_char(CHAR_DOT);
      put_num(2, 2);
      put_char(CHAR_DOT);
      put_num(2023, 4);
      put_char(CHAR_SPACE);
      repeat (20) put_char(8'hFF);
      put_char(8'h00);
      send_text();
   endtask

   task automatic test_random_strings(int n_chars);
      int goal;
      int kind;
      int p;
      goal = chars_sent + n_chars;
      while (chars_sent < goal) begin
         text_q.delete();
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            build_date();
         end else if (kind < 85) begin
            build_date();
            if ($urandom_range(0, 1) == 0) begin
               p = $urandom_range(0, text_q.size() - 1);
               text_q[p] = 8'($urandom_range(0, 255));
            end else begin
               p = $urandom_range(1, 9);
               while (text_q.size() > p) void'(text_q.pop_back());
            end
         end else begin
            repeat ($urandom_range(1, 16)) put_char(8'($urandom_range(0, 255)));
         end
         send_text();
      end
   endtask

   // receiver side backpressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // compare each result transfer with the oldest queued date
   always @(posedge clock) begin : check_results
      date_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_dates.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, got %h", $time, rsp_tdata);
         end else begin
            want = expected_dates.pop_front();
            check_field("valid_res", want.ok, rsp_tdata[0]);
            check_field("error_code", want.err, rsp_tdata[3:1]);
            check_field("day_out", want.day, rsp_tdata[10:4]);
            check_field("month_out", want.month, rsp_tdata[17:11]);
            check_field("year_out", want.year, rsp_tdata[31:18]);
            dates_checked++;
         end
      end
   end

   // end the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog: no transfer for %0d cycles, %0d dates pending",
                  $time, IDLE_LIMIT, expected_dates.size());
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clear_date_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_valid_dates();
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
      test_error_codes();
      test_format_errors();
      test_long_strings();
      wait_all_results();

      // full rate, then gaps on both sides, then one side at a time
      tx_gaps_on   = 1'b0;
      rx_stalls_on = 1'b0;
      test_random_strings(300);
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
      test_random_strings(600);
      wait_all_results();
      tx_gaps_on   = 1'b0;
      test_random_strings(300);
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b0;
      test_random_strings(300);

      wait_all_results();
      repeat (8) @(posedge clock);
      $display("covered %0d date strings in %0d characters, %0d results compared",
               strings_sent, chars_sent, dates_checked);
      $display("calendar edges, all error codes, malformed and long strings, random gaps");
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
